// File: hdl/kpdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpdc_pkg: shared types and constants of the key press duration classifier
// Class codes, register indexes, reset values, stream packing and the
// structs that travel between the top level and the classifier core.
// ----------------------------------------------------------------------------
package kpdc_pkg;

    localparam int TimeW   = 32;
    localparam int ClassW  = 3;
    localparam int RepCntW = 16;
    localparam int LockW   = 10;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 32;

    // Stream packing, padded to whole bytes
    localparam int InDataW  = 40;
    localparam int OutDataW = 24;

    // Press classes
    localparam logic [ClassW-1:0] CLS_NONE      = 3'd0;
    localparam logic [ClassW-1:0] CLS_SHORT     = 3'd1;
    localparam logic [ClassW-1:0] CLS_LONG      = 3'd2;
    localparam logic [ClassW-1:0] CLS_KEEP_LONG = 3'd3;
    localparam logic [ClassW-1:0] CLS_REPEAT    = 3'd4;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_LONG_LIMIT      = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_KEEP_LONG_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_REPEAT_INTERVAL = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_LOCK_TICKS      = 2'd3;

    // Register reset values
    localparam logic [TimeW-1:0] LONG_LIMIT_RST      = 32'd1000;
    localparam logic [TimeW-1:0] KEEP_LONG_LIMIT_RST = 32'd5000;
    localparam logic [TimeW-1:0] REPEAT_INTERVAL_RST = 32'd200;
    localparam logic [LockW-1:0] LOCK_TICKS_RST      = 10'd300;

    typedef struct packed {
        logic [TimeW-1:0] long_limit;
        logic [TimeW-1:0] keep_long_limit;
        logic [TimeW-1:0] repeat_interval;
        logic [LockW-1:0] lock_ticks;
    } t_cfg;

    typedef struct packed {
        logic [ClassW-1:0]  press_class;
        logic [RepCntW-1:0] repeat_count;
        logic               key_down;
    } t_result;

endpackage

// File: hdl/kpdc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpdc_core: classifier state and single-step update
// Holds the press/repeat/lock state and computes one result per advanced item
// from the registered key level and time sample.
// ----------------------------------------------------------------------------
module kpdc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_key_level,
    input  logic [kpdc_pkg::TimeW-1:0]    i_now_time,
    input  kpdc_pkg::t_cfg                i_cfg,
    output kpdc_pkg::t_result             o_result
);

    logic                           r_prev_level,   n_prev_level;
    logic [kpdc_pkg::TimeW-1:0]     r_press_start,  n_press_start;
    logic [kpdc_pkg::TimeW-1:0]     r_repeat_start, n_repeat_start;
    logic [kpdc_pkg::ClassW-1:0]    r_class,        n_class;
    logic [kpdc_pkg::RepCntW-1:0]   r_rep_cnt,      n_rep_cnt;
    logic [kpdc_pkg::LockW-1:0]     r_lock_cnt,     n_lock_cnt;

    logic [kpdc_pkg::TimeW-1:0]     held_time;
    logic [kpdc_pkg::TimeW-1:0]     rep_time;
    logic [kpdc_pkg::ClassW-1:0]    mid_class;
    logic [kpdc_pkg::LockW-1:0]     mid_lock;
    logic [kpdc_pkg::LockW-1:0]     lock_inc;

    assign held_time = i_now_time - r_press_start;
    assign rep_time  = i_now_time - r_repeat_start;
    assign lock_inc  = mid_lock + kpdc_pkg::LockW'(1);

    always_comb begin
        n_press_start  = r_press_start;
        n_repeat_start = r_repeat_start;
        n_rep_cnt      = r_rep_cnt;
        mid_class      = r_class;
        mid_lock       = r_lock_cnt;

        if (!i_key_level) begin
            if (r_prev_level) begin
                n_press_start  = i_now_time;
                n_repeat_start = i_now_time;
                n_rep_cnt      = '0;
            end else if (held_time > i_cfg.keep_long_limit) begin
                // held past keep-long: no more repeats
            end else if (rep_time > i_cfg.repeat_interval) begin
                n_repeat_start = i_now_time;
                mid_class      = kpdc_pkg::CLS_REPEAT;
                n_rep_cnt      = r_rep_cnt + kpdc_pkg::RepCntW'(1);
            end
        end else if (!r_prev_level) begin
            if (held_time > i_cfg.keep_long_limit) begin
                mid_class = kpdc_pkg::CLS_KEEP_LONG;
            end else if (held_time > i_cfg.long_limit) begin
                mid_class = kpdc_pkg::CLS_LONG;
            end else begin
                mid_class = kpdc_pkg::CLS_SHORT;
            end
            mid_lock = '0;
        end

        n_prev_level = i_key_level;
        n_class      = mid_class;
        n_lock_cnt   = mid_lock;

        // count scan steps of a short or long class, release step included
        if (mid_class == kpdc_pkg::CLS_SHORT || mid_class == kpdc_pkg::CLS_LONG) begin
            if (lock_inc >= i_cfg.lock_ticks) begin
                n_class    = kpdc_pkg::CLS_NONE;
                n_lock_cnt = '0;
            end else begin
                n_lock_cnt = lock_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b1;
            r_press_start  <= '0;
            r_repeat_start <= '0;
            r_class        <= kpdc_pkg::CLS_NONE;
            r_rep_cnt      <= '0;
            r_lock_cnt     <= '0;
        end else if (i_advance) begin
            r_prev_level   <= n_prev_level;
            r_press_start  <= n_press_start;
            r_repeat_start <= n_repeat_start;
            r_class        <= n_class;
            r_rep_cnt      <= n_rep_cnt;
            r_lock_cnt     <= n_lock_cnt;
        end
    end

    assign o_result.press_class  = n_class;
    assign o_result.repeat_count = n_rep_cnt;
    assign o_result.key_down     = ~i_key_level;

endmodule

// File: hdl/key_press_duration_classifier.sv
`timescale 1ns / 1ps
// From input accept to result valid an item passes the input register, then the result register.
// Throughput: one item per cycle while the result stream is not stalled; the core updates its state once per item.
// While a finished result waits, the input register takes one more item, then the input stalls.
// Reset (synchronous, active low): both stages empty, key state released,
// configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// key_press_duration_classifier: short/long/keep-long/repeat key classifier
// Samples an active-low key level with a time stamp per item and emits the
// current press class, repeat count and key-down flag for each item.
// ----------------------------------------------------------------------------
module key_press_duration_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [kpdc_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [kpdc_pkg::CfgW-1:0]       i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kpdc_pkg::InDataW-1:0]    s_axis_tdata,  // [0] key_level, [32:1] now_time
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kpdc_pkg::OutDataW-1:0]   m_axis_tdata   // [2:0] press_class,
                                                           // [18:3] repeat_count, [19] key_down
);

    kpdc_pkg::t_cfg     r_cfg;
    kpdc_pkg::t_result  core_result;
    kpdc_pkg::t_result  r_result;

    logic                           r_in_valid;
    logic                           r_in_level;
    logic [kpdc_pkg::TimeW-1:0]     r_in_time;
    logic                           r_out_valid;
    logic                           advance;
    logic                           in_accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_limit      <= kpdc_pkg::LONG_LIMIT_RST;
            r_cfg.keep_long_limit <= kpdc_pkg::KEEP_LONG_LIMIT_RST;
            r_cfg.repeat_interval <= kpdc_pkg::REPEAT_INTERVAL_RST;
            r_cfg.lock_ticks      <= kpdc_pkg::LOCK_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                kpdc_pkg::REG_LONG_LIMIT:      r_cfg.long_limit      <= i_cfg_wdata;
                kpdc_pkg::REG_KEEP_LONG_LIMIT: r_cfg.keep_long_limit <= i_cfg_wdata;
                kpdc_pkg::REG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_wdata;
                kpdc_pkg::REG_LOCK_TICKS:
                    r_cfg.lock_ticks <= i_cfg_wdata[kpdc_pkg::LockW-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance the registered item into the result register when there is room
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_level <= s_axis_tdata[0];
            r_in_time  <= s_axis_tdata[kpdc_pkg::TimeW:1];
        end
    end

    kpdc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_key_level (r_in_level),
        .i_now_time  (r_in_time),
        .i_cfg       (r_cfg),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_result.key_down, r_result.repeat_count,
                            r_result.press_class};

endmodule

// File: hdl/kpdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpdc_checker: port-level checks of the key press duration classifier
// Watches the result stream for emptiness after reset, legal class codes, stall stability, zero padding and
// consistency between the class and the key-down flag.
// ----------------------------------------------------------------------------
module kpdc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [kpdc_pkg::OutDataW-1:0]   m_axis_tdata
);

    // nothing comes out in the cycle after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] == kpdc_pkg::CLS_NONE
                       || m_axis_tdata[2:0] == kpdc_pkg::CLS_SHORT
                       || m_axis_tdata[2:0] == kpdc_pkg::CLS_LONG
                       || m_axis_tdata[2:0] == kpdc_pkg::CLS_KEEP_LONG
                       || m_axis_tdata[2:0] == kpdc_pkg::CLS_REPEAT)
        else $error("illegal press class");

    // a release always replaces the repeat class
    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == kpdc_pkg::CLS_REPEAT |-> m_axis_tdata[19])
        else $error("repeat class with key released");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:20] == 4'b0000)
        else $error("result padding not zero");

endmodule

bind key_press_duration_classifier kpdc_checker u_kpdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
